FILE: rtl/cffsa_pkg.sv
// Package for the circular first-free slot allocator.
// Holds the field widths, the status and kind codes, the controller states
// and the lowest-set-bit search used on one word of the free map.
package cffsa_pkg;

  localparam int INDEX_W  = 10;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 2;
  localparam int WORD_W   = 64;
  localparam int BIT_W    = 6;
  localparam int COUNT_RESET_MAX = 1024;

  typedef enum logic [STATUS_W-1:0] {
    STAT_GRANTED   = 2'd0,
    STAT_NONE_FREE = 2'd1,
    STAT_RELEASED  = 2'd2,
    STAT_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic {
    KIND_CLAIM   = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RELEASE,
    S_SCAN,
    S_HOLD
  } state_t;

  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

FILE: rtl/cffsa_ifs.sv
// Handshake interfaces for the slot allocator's request and response channels.
// Depends on cffsa_pkg for the field widths.
interface cffsa_req_if import cffsa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [INDEX_W-1:0] slot_index;

  modport source (output valid, output kind, output slot_index, input ready);
  modport sink (input valid, input kind, input slot_index, output ready);
endinterface

interface cffsa_rsp_if import cffsa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [INDEX_W-1:0]  granted_slot;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output granted_slot, output status, input ready);
  modport sink (input valid, input granted_slot, input status, output ready);
endinterface

FILE: rtl/cffsa_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module cffsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/circular_first_free_slot_allocator_unit.sv
// Circular first-free slot allocator. The free map sits in one RAM of 64-slot
// words read one word per cycle. A claim visits at most (slot_count - 1) / 64 + 2
// words of the map. After reset and after every slot_count write a clearing
// pass frees every slot, during which no transaction is accepted.
module circular_first_free_slot_allocator_unit import cffsa_pkg::*; #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  cffsa_req_if.sink          req,
  cffsa_rsp_if.source        rsp
);

  localparam int WORDS = (MAX_SLOTS + WORD_W - 1) / WORD_W;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int COUNT_RESET = (MAX_SLOTS < COUNT_RESET_MAX) ? MAX_SLOTS : COUNT_RESET_MAX;

  state_t             state, state_next;
  logic [COUNT_W-1:0] cnt;
  logic [WAW-1:0]     clr_addr, clr_addr_next;
  logic [WAW-1:0]     addr, addr_next;
  logic [WAW-1:0]     start_word, start_word_next;
  logic               wrapped, wrapped_next;
  logic [BIT_W-1:0]   lo_bit, lo_bit_next;
  logic [INDEX_W-1:0] pend_slot, pend_slot_next;
  status_t            pend_status, pend_status_next;
  logic               out_valid;
  logic [INDEX_W-1:0] out_slot;
  status_t            out_status;

  logic               ram_we, ram_re;
  logic [WAW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0]  ram_wdata, ram_rdata;

  logic [COUNT_W-1:0] cnt_m1;
  logic [WAW-1:0]     last_word;
  logic [BIT_W-1:0]   last_bit;
  logic [WORD_W-1:0]  lo_mask, last_mask, word_mask, hit_vec, bit_onehot;
  logic [BIT_W-1:0]   hit_bit;
  logic               hit, out_free, bad_index;
  logic [COUNT_W-1:0] cfg_clamped;

  cffsa_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cnt_m1    = cnt - COUNT_W'(1);
  assign last_word = WAW'(cnt_m1 >> BIT_W);
  assign last_bit  = cnt_m1[BIT_W-1:0];
  assign lo_mask   = {WORD_W{1'b1}} << lo_bit;
  assign last_mask = {WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - last_bit);
  assign word_mask = ((!wrapped && addr == start_word) ? lo_mask : {WORD_W{1'b1}}) &
                     ((addr == last_word) ? last_mask : {WORD_W{1'b1}});
  assign hit_vec   = ram_rdata & word_mask;
  assign hit       = |hit_vec;
  assign hit_bit   = lowest_set(hit_vec);
  assign out_free  = !out_valid || rsp.ready;
  assign bad_index = {1'b0, req.slot_index} >= cnt;

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.granted_slot = out_slot;
  assign rsp.status       = out_status;

  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_clamped = COUNT_W'(1);
    end else if (32'(cfg_wdata) > MAX_SLOTS) begin
      cfg_clamped = COUNT_W'(MAX_SLOTS);
    end else begin
      cfg_clamped = cfg_wdata;
    end
  end

  always_comb begin
    state_next       = state;
    clr_addr_next    = clr_addr;
    addr_next        = addr;
    start_word_next  = start_word;
    wrapped_next     = wrapped;
    lo_bit_next      = lo_bit;
    pend_slot_next   = pend_slot;
    pend_status_next = pend_status;
    ram_we           = 1'b0;
    ram_waddr        = addr;
    ram_wdata        = ram_rdata;
    ram_re           = 1'b0;
    ram_raddr        = addr;
    bit_onehot       = {{(WORD_W-1){1'b0}}, 1'b1} << hit_bit;

    case (state)
      S_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        ram_wdata     = {WORD_W{1'b1}};
        clr_addr_next = clr_addr + WAW'(1);
        if (clr_addr == WAW'(WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          start_word_next = WAW'(req.slot_index >> BIT_W);
          addr_next       = WAW'(req.slot_index >> BIT_W);
          lo_bit_next     = req.slot_index[BIT_W-1:0];
          wrapped_next    = 1'b0;
          ram_raddr       = WAW'(req.slot_index >> BIT_W);
          if (bad_index) begin
            pend_slot_next   = '0;
            pend_status_next = STAT_BAD_INDEX;
            state_next       = S_HOLD;
          end else if (req.kind == KIND_RELEASE) begin
            ram_re     = 1'b1;
            state_next = S_RELEASE;
          end else begin
            ram_re     = 1'b1;
            state_next = S_SCAN;
          end
        end
      end
      S_RELEASE: begin
        bit_onehot       = {{(WORD_W-1){1'b0}}, 1'b1} << lo_bit;
        ram_we           = 1'b1;
        ram_wdata        = ram_rdata | bit_onehot;
        pend_slot_next   = '0;
        pend_status_next = STAT_RELEASED;
        state_next       = S_HOLD;
      end
      S_SCAN: begin
        if (hit) begin
          ram_we           = 1'b1;
          ram_wdata        = ram_rdata & ~bit_onehot;
          pend_slot_next   = INDEX_W'({addr, hit_bit});
          pend_status_next = STAT_GRANTED;
          state_next       = S_HOLD;
        end else if (wrapped && addr == start_word) begin
          pend_slot_next   = '0;
          pend_status_next = STAT_NONE_FREE;
          state_next       = S_HOLD;
        end else begin
          if (!wrapped && addr == last_word) begin
            addr_next    = '0;
            wrapped_next = 1'b1;
          end else begin
            addr_next = addr + WAW'(1);
          end
          ram_re    = 1'b1;
          ram_raddr = addr_next;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= COUNT_W'(COUNT_RESET);
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        state    <= S_CLEAR;
        cnt      <= cfg_clamped;
        clr_addr <= '0;
      end else begin
        state    <= state_next;
        clr_addr <= clr_addr_next;
      end
      if (state == S_HOLD && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr        <= addr_next;
    start_word  <= start_word_next;
    wrapped     <= wrapped_next;
    lo_bit      <= lo_bit_next;
    pend_slot   <= pend_slot_next;
    pend_status <= pend_status_next;
    if (state == S_HOLD && out_free) begin
      out_slot   <= pend_slot;
      out_status <= pend_status;
    end
  end

  // The free map is written only by the clearing pass, a release or a grant.
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_RELEASE || state == S_SCAN))
    else $error("free map written outside clear, release or scan");

  // The search never visits a word beyond the last slot in use.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (addr <= last_word))
    else $error("scan address beyond last word in use");

  // An accepted transaction always leaves the controller busy in the cycle after it is accepted.
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state != S_IDLE))
    else $error("controller idle straight after accepting a transaction");

endmodule

FILE: tb/sv/tb_circular_first_free_slot_allocator_unit.sv
// Self-checking testbench for the circular first-free slot allocator unit.
// It depends on cffsa_pkg, the request and response interfaces and the unit itself;
// a slot map kept alongside the unit predicts the response of every transaction.
module tb_circular_first_free_slot_allocator_unit;
  import cffsa_pkg::*;

  localparam int MAX_SLOTS    = 1024;
  localparam int STALL_LIMIT  = 2000;
  localparam int TARGET_ITEMS = 1500;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [INDEX_W-1:0] granted_slot;
    status_t            status;
  } alloc_result_t;

  class alloc_tracker;
    bit              slot_free [MAX_SLOTS];
    int unsigned     slots_in_use;
    alloc_result_t   awaited_results [$];
    int unsigned     failures;

    function new();
      failures = 0;
      set_slot_count(COUNT_W'(COUNT_RESET_MAX));
    endfunction

    function void set_slot_count(logic [COUNT_W-1:0] value);
      if (value == 0) begin
        slots_in_use = 1;
      end else if (value > MAX_SLOTS) begin
        slots_in_use = MAX_SLOTS;
      end else begin
        slots_in_use = 32'(value);
      end
      foreach (slot_free[i]) slot_free[i] = 1'b1;
    endfunction

    function void note_request(kind_t kind, logic [INDEX_W-1:0] idx);
      alloc_result_t res;
      int found;
      res.granted_slot = '0;
      found = -1;
      if (idx >= slots_in_use) begin
        res.status = STAT_BAD_INDEX;
      end else if (kind == KIND_RELEASE) begin
        slot_free[idx] = 1'b1;
        res.status = STAT_RELEASED;
      end else begin
        for (int s = int'(idx); s < slots_in_use && found < 0; s++) begin
          if (slot_free[s]) found = s;
        end
        for (int s = 0; s < int'(idx) && found < 0; s++) begin
          if (slot_free[s]) found = s;
        end
        if (found >= 0) begin
          slot_free[found] = 1'b0;
          res.granted_slot = INDEX_W'(found);
          res.status = STAT_GRANTED;
        end else begin
          res.status = STAT_NONE_FREE;
        end
      end
      awaited_results.push_back(res);
    endfunction

    function void check_response(logic [INDEX_W-1:0] granted, logic [STATUS_W-1:0] status);
      alloc_result_t want;
      if (awaited_results.size() == 0) begin
        failures++;
        $display("%0t: response with none awaited, expected nothing, actual slot %0d status %0d",
                 $time, granted, status);
        return;
      end
      want = awaited_results.pop_front();
      if (granted !== want.granted_slot) begin
        failures++;
        $display("%0t: granted_slot expected %0d actual %0d", $time, want.granted_slot, granted);
      end
      if (status !== want.status) begin
        failures++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
      end
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;

  cffsa_req_if req_bus ();
  cffsa_rsp_if rsp_bus ();

  alloc_tracker tracker;
  bit           quiet = 1'b0;
  int unsigned  items_sent = 0;
  int unsigned  idle_cycles = 0;

  circular_first_free_slot_allocator_unit #(.MAX_SLOTS(MAX_SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_bus),
    .rsp       (rsp_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic [INDEX_W-1:0] pick_taken_slot();
    int unsigned start;
    int unsigned s;
    start = $urandom_range(0, tracker.slots_in_use - 1);
    for (int unsigned n = 0; n < tracker.slots_in_use; n++) begin
      s = (start + n) % tracker.slots_in_use;
      if (!tracker.slot_free[s]) return INDEX_W'(s);
    end
    return INDEX_W'(start);
  endfunction

  task automatic send_request(kind_t kind, logic [INDEX_W-1:0] idx);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      req_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_bus.kind = kind;
    req_bus.slot_index = idx;
    req_bus.valid = 1'b1;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    tracker.note_request(kind, idx);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_slot_count(logic [COUNT_W-1:0] value);
    req_bus.valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    cfg_wdata = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.set_slot_count(value);
  endtask

  task automatic send_random_item(int claim_pct);
    int unsigned roll;
    int unsigned limit;
    roll = $urandom_range(0, 99);
    limit = tracker.slots_in_use;
    if (limit < MAX_SLOTS && roll < 6) begin
      send_request(kind_t'($urandom_range(0, 1)), INDEX_W'($urandom_range(limit, MAX_SLOTS - 1)));
    end else if (roll < claim_pct) begin
      send_request(KIND_CLAIM, INDEX_W'($urandom_range(0, limit - 1)));
    end else if ($urandom_range(0, 3) != 0) begin
      send_request(KIND_RELEASE, pick_taken_slot());
    end else begin
      send_request(KIND_RELEASE, INDEX_W'($urandom_range(0, limit - 1)));
    end
  endtask

  initial begin
    int gap;
    rsp_bus.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        rsp_bus.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_bus.ready = 1'b1;
      do @(posedge clk); while (rsp_bus.valid !== 1'b1);
      tracker.check_response(rsp_bus.granted_slot, rsp_bus.status);
      @(negedge clk);
    end
  end

  initial begin
    logic [COUNT_W-1:0] count_value;
    int                 claim_pct;
    int                 phase_items;
    tracker = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_bus.valid = 1'b0;
    req_bus.kind = KIND_CLAIM;
    req_bus.slot_index = '0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // Full range after reset: wrap-around, double release and reclaim.
    send_request(KIND_CLAIM, 10'd0);
    send_request(KIND_CLAIM, 10'd0);
    send_request(KIND_CLAIM, 10'd1023);
    send_request(KIND_CLAIM, 10'd1023);
    send_request(KIND_RELEASE, 10'd1);
    send_request(KIND_RELEASE, 10'd1);
    send_request(KIND_CLAIM, 10'd0);
    send_request(KIND_RELEASE, 10'd1023);
    send_request(KIND_CLAIM, 10'd1023);

    // A single slot: exhaustion and out-of-range indexes.
    write_slot_count(11'd1);
    send_request(KIND_CLAIM, 10'd0);
    send_request(KIND_CLAIM, 10'd0);
    send_request(KIND_CLAIM, 10'd1);
    send_request(KIND_RELEASE, 10'd1023);
    send_request(KIND_RELEASE, 10'd0);
    send_request(KIND_CLAIM, 10'd0);

    write_slot_count(11'd0);
    send_request(KIND_CLAIM, 10'd0);
    send_request(KIND_RELEASE, 10'd5);

    write_slot_count(11'd2047);
    send_request(KIND_CLAIM, 10'd512);
    send_request(KIND_RELEASE, 10'd512);
    send_request(KIND_CLAIM, 10'd1023);

    write_slot_count(11'd2);
    send_request(KIND_CLAIM, 10'd1);
    send_request(KIND_CLAIM, 10'd1);
    send_request(KIND_CLAIM, 10'd0);
    send_request(KIND_RELEASE, 10'd1);

    while (items_sent < TARGET_ITEMS) begin
      case ($urandom_range(0, 9))
        0: count_value = 11'd0;
        1: count_value = 11'd1;
        2: count_value = 11'd2;
        3: count_value = 11'd1024;
        4: count_value = COUNT_W'($urandom_range(1025, 2047));
        5: count_value = 11'd1023;
        6: count_value = COUNT_W'($urandom_range(63, 65));
        default: count_value = COUNT_W'($urandom_range(3, 100));
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      claim_pct = $urandom_range(35, 85);
      write_slot_count(count_value);
      phase_items = (tracker.slots_in_use >= 512) ? 200 : $urandom_range(40, 120);
      repeat (phase_items) send_random_item(claim_pct);
    end

    req_bus.valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (tracker.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
